@@ rtl/lms_fir_pkg.sv @@
// Shared types and constants for the LMS adaptive FIR filter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package lms_fir_pkg;

	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 24;
	localparam int STEP_W   = 16;
	localparam int ESQ_W    = 31;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 2;

	localparam logic [ADDR_W-1:0] REG_STEP_SIZE = 2'd0;
	localparam logic [STEP_W-1:0] STEP_RESET    = 16'd9175;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [SAMPLE_W-1:0] desired;
		logic                       adapt;
		logic                       clear;
	} samp_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filter_out;
		logic signed [SAMPLE_W-1:0] error;
		logic        [ESQ_W-1:0]    error_squared;
	} res_t;

	typedef struct packed {
		logic load;
		logic mac_mul;
		logic mac_acc;
		logic round;
		logic err;
		logic prod;
		logic upd_mul;
		logic upd_w;
		logic out_load;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/lms_fir_dp.sv @@
// Datapath of the LMS adaptive FIR filter: delay line, weights, shared MAC and update unit.
// Depends on lms_fir_pkg; driven by commands from lms_fir_ctrl.
`default_nettype none

module lms_fir_dp #(
	parameter int TAPS = 8
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire lms_fir_pkg::cmd_t               cmd,
	input  wire lms_fir_pkg::samp_t              samp,
	input  wire logic [lms_fir_pkg::STEP_W-1:0]  step_size,
	output lms_fir_pkg::res_t                    res
);

	localparam int SW    = lms_fir_pkg::SAMPLE_W;
	localparam int WW    = lms_fir_pkg::WEIGHT_W;
	localparam int PW    = WW + SW;
	localparam int ACC_W = PW + $clog2(TAPS) + 1;
	localparam int MEW   = lms_fir_pkg::STEP_W + 1 + SW;
	localparam int UPW   = MEW + SW;

	localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(2 ** 19);
	localparam logic signed [ACC_W-1:0] Y_MAX   = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] Y_MIN   = ACC_W'(-32768);
	localparam logic signed [UPW-1:0]   UPD_RND = UPW'(2 ** 25);

	logic signed [SW-1:0]    dl_q [TAPS];
	logic signed [WW-1:0]    w_q  [TAPS];
	logic signed [SW-1:0]    d_q;
	logic signed [PW-1:0]    mac_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SW-1:0]    y_q;
	logic signed [SW-1:0]    e_q;
	logic signed [MEW-1:0]   me_q;
	logic [lms_fir_pkg::ESQ_W-1:0] esq_q;
	logic signed [UPW-1:0]   upd_s1;
	lms_fir_pkg::res_t       res_q;

	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [ACC_W-1:0] y_full;
	logic signed [SW-1:0]    y_sat;
	logic signed [SW:0]      e_diff;
	logic signed [SW-1:0]    e_sat;
	logic signed [2*SW-1:0]  e_sq;
	logic signed [UPW-1:0]   upd_rnd;
	logic signed [UPW-1:0]   delta;
	logic signed [WW:0]      w_sum;
	logic signed [WW-1:0]    w_new;

	always_comb begin
		acc_rnd = acc_q + ACC_RND;
		y_full  = acc_rnd >>> 20;
		if (y_full > Y_MAX) begin
			y_sat = 16'sh7fff;
		end else if (y_full < Y_MIN) begin
			y_sat = 16'sh8000;
		end else begin
			y_sat = y_full[SW-1:0];
		end
	end

	always_comb begin
		e_diff = {d_q[SW-1], d_q} - {y_q[SW-1], y_q};
		if (e_diff[SW] != e_diff[SW-1]) begin
			e_sat = e_diff[SW] ? 16'sh8000 : 16'sh7fff;
		end else begin
			e_sat = e_diff[SW-1:0];
		end
		e_sq = e_q * e_q;
	end

	always_comb begin
		upd_rnd = upd_s1 + UPD_RND;
		delta   = upd_rnd >>> 26;
		w_sum   = {w_q[0][WW-1], w_q[0]} + delta[WW:0];
		if (w_sum[WW] != w_sum[WW-1]) begin
			w_new = w_sum[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
		end else begin
			w_new = w_sum[WW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) dl_q[i] <= '0;
		end else if (cmd.load) begin
			dl_q[0] <= samp.sample;
			for (int i = 1; i < TAPS; i++) dl_q[i] <= samp.clear ? '0 : dl_q[i-1];
		end else if (cmd.mac_mul || cmd.upd_mul) begin
			for (int i = 0; i < TAPS - 1; i++) dl_q[i] <= dl_q[i+1];
			dl_q[TAPS-1] <= dl_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) w_q[i] <= '0;
		end else if (cmd.load) begin
			if (samp.clear) begin
				for (int i = 0; i < TAPS; i++) w_q[i] <= '0;
			end
		end else if (cmd.mac_mul) begin
			for (int i = 0; i < TAPS - 1; i++) w_q[i] <= w_q[i+1];
			w_q[TAPS-1] <= w_q[0];
		end else if (cmd.upd_w) begin
			for (int i = 0; i < TAPS - 1; i++) w_q[i] <= w_q[i+1];
			w_q[TAPS-1] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q   <= samp.desired;
			acc_q <= '0;
		end else if (cmd.mac_acc) begin
			acc_q <= acc_q + ACC_W'(mac_s1);
		end
		if (cmd.mac_mul) begin
			mac_s1 <= w_q[0] * dl_q[0];
		end
		if (cmd.round) begin
			y_q <= y_sat;
		end
		if (cmd.err) begin
			e_q <= e_sat;
		end
		if (cmd.prod) begin
			esq_q <= e_sq[lms_fir_pkg::ESQ_W-1:0];
			me_q  <= $signed({1'b0, step_size}) * e_q;
		end
		if (cmd.upd_mul) begin
			upd_s1 <= me_q * dl_q[0];
		end
		if (cmd.out_load) begin
			res_q.filter_out    <= y_q;
			res_q.error         <= e_q;
			res_q.error_squared <= esq_q;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

@@ rtl/lms_fir_ctrl.sv @@
// Controller of the LMS adaptive FIR filter: sequences the MAC and update passes.
// Depends on lms_fir_pkg; issues commands to lms_fir_dp and owns the handshakes.
`default_nettype none

module lms_fir_ctrl #(
	parameter int TAPS = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     samp_valid,
	input  wire                     samp_adapt,
	output logic                    samp_stall,
	output logic                    res_valid,
	input  wire                     res_stall,
	output lms_fir_pkg::cmd_t       cmd
);

	localparam int CNT_W = $clog2(TAPS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAC   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ERR   = 3'd3;
	localparam logic [2:0] ST_PROD  = 3'd4;
	localparam logic [2:0] ST_UPD   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             adapt_q;
	logic             res_valid_q;
	logic             accept;
	logic             out_free;

	assign samp_stall = (state_q != ST_IDLE);
	assign accept     = samp_valid && !samp_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign res_valid  = res_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.mac_mul  = (state_q == ST_MAC) && (cnt_q != CNT_LAST);
		cmd.mac_acc  = (state_q == ST_MAC) && (cnt_q != '0);
		cmd.round    = (state_q == ST_ROUND);
		cmd.err      = (state_q == ST_ERR);
		cmd.prod     = (state_q == ST_PROD);
		cmd.upd_mul  = (state_q == ST_UPD) && (cnt_q != CNT_LAST);
		cmd.upd_w    = (state_q == ST_UPD) && (cnt_q != '0);
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			adapt_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MAC;
						cnt_q   <= '0;
						adapt_q <= samp_adapt;
					end
				end
				ST_MAC: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ROUND: state_q <= ST_ERR;
				ST_ERR:   state_q <= ST_PROD;
				ST_PROD: begin
					cnt_q   <= '0;
					state_q <= adapt_q ? ST_UPD : ST_DONE;
				end
				ST_UPD: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	a_accept_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MAC) && (cnt_q == '0))
		else $error("request accepted but MAC pass did not start");

	a_upd_only_adapt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> adapt_q)
		else $error("weight update pass without adapt");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("tap counter beyond last tap");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |=> !$past(cmd.out_load))
		else $error("result overwritten while stalled");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == ST_IDLE) && res_valid_q)
		else $error("result load did not return to idle");

endmodule

`default_nettype wire

@@ rtl/lms_adaptive_fir.sv @@
// A request is taken only in idle: no new request is taken until the result of the one
// before has been loaded for output, and the update pass runs only with adapt high.
// One multiplier makes a pass over the taps for the output and a second multiplier a
// pass for the weight update; a stalled result holds the next request back. Reset clears
// the weights and the delay line, sets the step size to 9175, and takes effect at once.
// Top level: APB register, lms_fir_ctrl and lms_fir_dp; depends on lms_fir_pkg.
`default_nettype none

module lms_adaptive_fir #(
	parameter int TAPS = 8
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire logic [lms_fir_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [lms_fir_pkg::DATA_W-1:0]   pwdata,
	output logic [lms_fir_pkg::DATA_W-1:0]        prdata,
	output logic                                  pready,
	input  wire                                   samp_valid,
	output logic                                  samp_stall,
	input  wire lms_fir_pkg::samp_t               samp,
	output logic                                  res_valid,
	input  wire                                   res_stall,
	output lms_fir_pkg::res_t                     res
);

	logic [lms_fir_pkg::STEP_W-1:0] step_q;
	lms_fir_pkg::cmd_t              cmd;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lms_fir_pkg::STEP_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr == lms_fir_pkg::REG_STEP_SIZE) begin
			step_q <= pwdata[lms_fir_pkg::STEP_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr)
			lms_fir_pkg::REG_STEP_SIZE: prdata = lms_fir_pkg::DATA_W'(step_q);
			default:                    prdata = '0;
		endcase
	end

	lms_fir_ctrl #(
		.TAPS (TAPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.samp_valid (samp_valid),
		.samp_adapt (samp.adapt),
		.samp_stall (samp_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.cmd        (cmd)
	);

	lms_fir_dp #(
		.TAPS (TAPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.samp      (samp),
		.step_size (step_q),
		.res       (res)
	);

endmodule

`default_nettype wire
